/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication broken");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication broken");

`endif

/* src/lrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer package
// Canvas geometry, transaction types and pixel addressing shared by the core.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 256;
    localparam int FB_DEPTH      = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int ADDR_W        = $clog2(FB_DEPTH);
    localparam int PIX_W         = 2;
    localparam int COORD_W       = 12;
    localparam int ERR_W         = 26;

    localparam logic [PIX_W-1:0] LINE_VALUE  = 2'd1;
    localparam logic [PIX_W-1:0] BLANK_VALUE = 2'd0;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic
    {
        OP_DRAW = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t opcode;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
    } cmd_t;

    typedef struct packed
    {
        pix_t read_value;
        logic was_read;
    } rsp_t;

    typedef struct packed
    {
        logic  en;
        addr_t addr;
        pix_t  data;
    } wr_req_t;

    typedef struct packed
    {
        logic busy;
        logic last;
    } walk_stat_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_RESP
    } state_t;

    function automatic logic on_canvas(coord_t x, coord_t y);
        return !x[COORD_W-1] && !y[COORD_W-1]
            && ({1'b0, x} < (COORD_W+1)'(CANVAS_WIDTH))
            && ({1'b0, y} < (COORD_W+1)'(CANVAS_HEIGHT));
    endfunction

    function automatic addr_t pix_addr(coord_t x, coord_t y);
        int v;
        v = int'(y) * CANVAS_WIDTH + int'(x);
        return addr_t'(v);
    endfunction

endpackage

/* src/lrf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lrf_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 2
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/lrf_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line walker
// Orders the endpoints and walks a 4-connected staircase, one pixel per cycle.
// ----------------------------------------------------------------------------
module lrf_walk
    import lrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  cmd_t       cmd,
    output wr_req_t    wr,
    output walk_stat_t stat
);

    logic                    run_reg, run_next;
    coord_t                  cx_reg, cx_next;
    coord_t                  cy_reg, cy_next;
    coord_t                  x1_reg, x1_next;
    coord_t                  y1_reg, y1_next;
    logic [COORD_W-1:0]      dx_reg, dx_next;
    logic signed [COORD_W:0] dy_reg, dy_next;
    logic signed [ERR_W-1:0] e_reg, e_next;

    logic                    swap;
    coord_t                  x0, y0, x1, y1;
    logic                    at_end;
    logic                    step_x;
    logic                    dy_pos;
    logic signed [ERR_W-1:0] dx_ext;
    logic signed [ERR_W-1:0] dy_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        e_reg  <= e_next;
    end

    always_comb
    begin
        swap   = cmd.end_x < cmd.start_x;
        x0     = swap ? cmd.end_x : cmd.start_x;
        y0     = swap ? cmd.end_y : cmd.start_y;
        x1     = swap ? cmd.start_x : cmd.end_x;
        y1     = swap ? cmd.start_y : cmd.end_y;

        at_end = (cx_reg == x1_reg) && (cy_reg == y1_reg);
        dy_pos = !dy_reg[COORD_W] && (dy_reg != '0);
        dx_ext = signed'({{(ERR_W-COORD_W){1'b0}}, dx_reg});
        dy_ext = ERR_W'(dy_reg);

        if (dy_reg == '0)
        begin
            step_x = 1'b1;
        end
        else if (dx_reg == '0)
        begin
            step_x = 1'b0;
        end
        else if (dy_pos)
        begin
            step_x = e_reg > 0;
        end
        else
        begin
            step_x = e_reg < 0;
        end

        run_next = run_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        x1_next  = x1_reg;
        y1_next  = y1_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        e_next   = e_reg;

        if (start)
        begin
            run_next = 1'b1;
            cx_next  = x0;
            cy_next  = y0;
            x1_next  = x1;
            y1_next  = y1;
            dx_next  = COORD_W'({x1[COORD_W-1], x1} - {x0[COORD_W-1], x0});
            dy_next  = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
            e_next   = '0;
        end
        else if (run_reg)
        begin
            if (at_end)
            begin
                run_next = 1'b0;
            end
            else if (step_x)
            begin
                cx_next = cx_reg + coord_t'(1);
                e_next  = e_reg - dy_ext;
            end
            else if (dy_pos)
            begin
                cy_next = cy_reg + coord_t'(1);
                e_next  = e_reg + dx_ext;
            end
            else
            begin
                cy_next = cy_reg - coord_t'(1);
                e_next  = e_reg - dx_ext;
            end
        end

        wr.en     = run_reg && on_canvas(cx_reg, cy_reg);
        wr.addr   = pix_addr(cx_reg, cy_reg);
        wr.data   = LINE_VALUE;
        stat.busy = run_reg;
        stat.last = run_reg && at_end;
    end

endmodule

/* src/line_rasterizer_framebuffer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer frame buffer core
// A read passes through the states READ and RESP after acceptance; a draw
// stays in DRAW until its last staircase pixel and then enters RESP, the walker
// writing one pixel per cycle through the single RAM write port. One command is
// in flight at a time, so cmd_ready returns only once RESP registers the response.
// After reset all CANVAS_WIDTH * CANVAS_HEIGHT RAM addresses are written blank
// (65536 on a 256 by 256 canvas) before the first command is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_rasterizer_framebuffer_core
    import lrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    state_t     state_reg, state_next;
    addr_t      clr_cnt_reg, clr_cnt_next;
    logic       rd_on_reg, rd_on_next;
    rsp_t       res_reg, res_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_data_reg, rsp_data_next;

    logic       accept;
    logic       walk_start;
    logic       rd_en;
    pix_t       rd_data;
    wr_req_t    walk_wr;
    wr_req_t    ram_wr;
    walk_stat_t walk_stat;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign accept     = cmd_valid && cmd_ready;
    assign walk_start = accept && (cmd_data.opcode == OP_DRAW);
    assign rd_en      = accept && (cmd_data.opcode == OP_READ);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    lrf_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .cmd   (cmd_data),
        .wr    (walk_wr),
        .stat  (walk_stat)
    );

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_cnt_reg;
            ram_wr.data = BLANK_VALUE;
        end
        else
        begin
            ram_wr = walk_wr;
        end
    end

    lrf_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (pix_addr(cmd_data.start_x, cmd_data.start_y)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_on_reg    <= rd_on_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_on_next     = rd_on_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + addr_t'(1);
                if (clr_cnt_reg == addr_t'(FB_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_data.opcode == OP_READ)
                    begin
                        rd_on_next = on_canvas(cmd_data.start_x, cmd_data.start_y);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                if (walk_stat.last)
                begin
                    res_next.read_value = BLANK_VALUE;
                    res_next.was_read   = 1'b0;
                    state_next          = ST_RESP;
                end
            end
            ST_READ:
            begin
                res_next.read_value = rd_on_reg ? rd_data : BLANK_VALUE;
                res_next.was_read   = 1'b1;
                state_next          = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEVER(a_ready_while_walking, cmd_ready && walk_stat.busy)
    `ASSERT_IMPL(a_write_only_clear_or_draw, ram_wr.en, (state_reg == ST_CLEAR) || (state_reg == ST_DRAW))
    `ASSERT_NEXT(a_read_goes_to_wait, rd_en, state_reg == ST_READ)

endmodule

/* bench/tb_line_rasterizer_framebuffer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer frame buffer core testbench
// Drives draw and read transactions through the core, keeping a shadow frame
// buffer that is painted with the same four-connected staircase walk. A short
// table of directed transactions hits clipping, axis runs, single points and
// the full coordinate range. A random mix of lines and pixel reads follows.
// Each response is checked field by field against its queued expected answer.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_framebuffer_core;
    import lrf_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RSP_HOLD     = 4000;

    typedef struct
    {
        cmd_t cmd;
        bit   fixed;
        pix_t want;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;

    pix_t       frame_model [FB_DEPTH];
    rsp_t       awaited_answers [$];
    probe_row_t probe_rows [$];

    int  error_count = 0;
    int  answers_seen = 0;
    int  quiet_cycles;
    int  n_draws;
    int  n_wide_draws;
    int  n_reads;
    int  n_lit_reads = 0;
    bit  no_idle;

    line_rasterizer_framebuffer_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void set_pixel(int x, int y);
        if (x >= 0 && x < CANVAS_WIDTH && y >= 0 && y < CANVAS_HEIGHT)
        begin
            frame_model[y * CANVAS_WIDTH + x] = LINE_VALUE;
        end
    endfunction

    function automatic pix_t pixel_lookup(int x, int y);
        if (x >= 0 && x < CANVAS_WIDTH && y >= 0 && y < CANVAS_HEIGHT)
        begin
            return frame_model[y * CANVAS_WIDTH + x];
        end
        return BLANK_VALUE;
    endfunction

    function automatic void paint_line(int ax, int ay, int bx, int by);
        int     t;
        int     dx;
        int     dy;
        int     cx;
        int     cy;
        int     wx;
        int     wy;
        int     sx;
        int     sy;
        longint lhs;
        longint rhs;
        bit     step_x;
        if (bx < ax)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        cx = ax;
        cy = ay;
        if (dx == 0 || dy == 0)
        begin
            sx = (dx > 0) ? 1 : 0;
            sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            while (1)
            begin
                set_pixel(cx, cy);
                if (cx == bx && cy == by)
                begin
                    break;
                end
                cx += sx;
                cy += sy;
            end
            return;
        end
        sy = (dy > 0) ? 1 : -1;
        wx = 0;
        wy = 0;
        while (1)
        begin
            set_pixel(cx, cy);
            if (cx == bx && cy == by)
            begin
                break;
            end
            lhs = longint'(wy) * longint'(dx);
            rhs = longint'(wx) * longint'(dy);
            step_x = (dy > 0) ? (lhs > rhs) : (lhs < rhs);
            if (step_x)
            begin
                cx++;
                wx++;
            end
            else
            begin
                cy += sy;
                wy += sy;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic cmd_t mk_cmd(opcode_t op, int sx, int sy, int ex, int ey);
        cmd_t c;
        c.opcode  = op;
        c.start_x = coord_t'(sx);
        c.start_y = coord_t'(sy);
        c.end_x   = coord_t'(ex);
        c.end_y   = coord_t'(ey);
        return c;
    endfunction

    task automatic add_row(opcode_t op, int sx, int sy, int ex, int ey, bit fixed,
                           pix_t want);
        probe_row_t row;
        row.cmd   = mk_cmd(op, sx, sy, ex, ey);
        row.fixed = fixed;
        row.want  = want;
        probe_rows = {probe_rows, row};
    endtask

    task automatic issue_cmd(cmd_t c, bit fixed, pix_t fixed_val);
        int   gap;
        rsp_t ans;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do @(posedge clk); while (!cmd_ready);
        ans.was_read = (c.opcode == OP_READ);
        if (c.opcode == OP_READ)
        begin
            ans.read_value = fixed ? fixed_val
                                   : pixel_lookup(int'(c.start_x), int'(c.start_y));
            n_reads++;
        end
        else
        begin
            paint_line(int'(c.start_x), int'(c.start_y), int'(c.end_x), int'(c.end_y));
            ans.read_value = BLANK_VALUE;
            n_draws++;
        end
        awaited_answers = {awaited_answers, ans};
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_line_rasterizer_framebuffer_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        int   stall_left;
        bit   long_hold_done;
        rsp_t want;
        stall_left     = 0;
        long_hold_done = 1'b0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                answers_seen++;
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: unexpected response, actual read_value %0d was_read %0d",
                             $time, rsp_data.read_value, rsp_data.was_read);
                    error_count++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, rsp_data.read_value);
                        error_count++;
                    end
                    if (rsp_data.was_read !== want.was_read)
                    begin
                        $display("%0t: was_read expected %0d actual %0d",
                                 $time, want.was_read, rsp_data.was_read);
                        error_count++;
                    end
                    if (want.was_read && want.read_value == LINE_VALUE)
                    begin
                        n_lit_reads++;
                    end
                end
            end
            if (!long_hold_done && answers_seen == 200)
            begin
                stall_left     = RSP_HOLD;
                long_hold_done = 1'b1;
            end
            else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int      i;
        int      pick;
        int      kind;
        int      sx;
        int      sy;
        int      ex;
        int      ey;
        int      last_x;
        int      last_y;
        opcode_t op;
        n_draws      = 0;
        n_wide_draws = 0;
        n_reads      = 0;
        no_idle      = 1'b0;
        last_x       = 0;
        last_y       = 0;
        foreach (frame_model[k])
        begin
            frame_model[k] = BLANK_VALUE;
        end
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_row(OP_READ, 0, 0, 0, 0, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 255, 255, -2048, 2047, 1'b1, BLANK_VALUE);
        add_row(OP_READ, -1, 0, 0, 0, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 256, 5, 0, 0, 1'b1, BLANK_VALUE);
        add_row(OP_READ, -2048, -2048, 2047, -2048, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 2047, 2047, -1, -1, 1'b1, BLANK_VALUE);
        add_row(OP_DRAW, 10, 10, 10, 10, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 10, 10, 0, 0, 1'b1, LINE_VALUE);
        add_row(OP_READ, 11, 10, 0, 0, 1'b1, BLANK_VALUE);
        add_row(OP_DRAW, 0, 0, 255, 0, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 255, 0, 0, 0, 1'b1, LINE_VALUE);
        add_row(OP_DRAW, 5, 300, 5, -20, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 5, 255, 0, 0, 1'b1, LINE_VALUE);
        add_row(OP_DRAW, 200, 50, 20, 150, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 20, 150, 0, 0, 1'b1, LINE_VALUE);
        add_row(OP_READ, 110, 100, 0, 0, 1'b0, BLANK_VALUE);
        add_row(OP_DRAW, -2048, -2048, 2047, 2047, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 128, 128, 0, 0, 1'b0, BLANK_VALUE);
        add_row(OP_DRAW, 2047, -2048, -2048, 2047, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 0, 255, 0, 0, 1'b0, BLANK_VALUE);
        add_row(OP_DRAW, 300, -5, -50, -5, 1'b1, BLANK_VALUE);
        add_row(OP_DRAW, -10, -10, -10, -10, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 255, 128, 0, 0, 1'b0, BLANK_VALUE);
        add_row(OP_DRAW, 30, 200, 40, 10, 1'b1, BLANK_VALUE);
        add_row(OP_READ, 40, 10, 0, 0, 1'b1, LINE_VALUE);

        foreach (probe_rows[r])
        begin
            issue_cmd(probe_rows[r].cmd, probe_rows[r].fixed, probe_rows[r].want);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 480 && i < 560);
            if (i == 350)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
                while (awaited_answers.size() != 0) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            kind = $urandom_range(0, 99);
            if (pick < 45)
            begin
                op = OP_READ;
                ex = int'($urandom_range(0, 4095)) - 2048;
                ey = int'($urandom_range(0, 4095)) - 2048;
                if (kind < 50)
                begin
                    sx = last_x + int'($urandom_range(0, 2)) - 1;
                    sy = last_y + int'($urandom_range(0, 2)) - 1;
                end
                else if (kind < 90)
                begin
                    sx = $urandom_range(0, 255);
                    sy = $urandom_range(0, 255);
                end
                else
                begin
                    sx = int'($urandom_range(0, 4095)) - 2048;
                    sy = int'($urandom_range(0, 4095)) - 2048;
                end
            end
            else
            begin
                op = OP_DRAW;
                sx = int'($urandom_range(0, 295)) - 20;
                sy = int'($urandom_range(0, 295)) - 20;
                if (kind < 5)
                begin
                    sx = int'($urandom_range(0, 4095)) - 2048;
                    sy = int'($urandom_range(0, 4095)) - 2048;
                    ex = int'($urandom_range(0, 4095)) - 2048;
                    ey = int'($urandom_range(0, 4095)) - 2048;
                    n_wide_draws++;
                end
                else if (kind < 20)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        ex = sx;
                        ey = sy + int'($urandom_range(0, 160)) - 80;
                    end
                    else
                    begin
                        ex = sx + int'($urandom_range(0, 160)) - 80;
                        ey = sy;
                    end
                end
                else
                begin
                    ex = sx + int'($urandom_range(0, 120)) - 60;
                    ey = sy + int'($urandom_range(0, 120)) - 60;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    last_x = sx;
                    last_y = sy;
                end
                else
                begin
                    last_x = ex;
                    last_y = ey;
                end
            end
            issue_cmd(mk_cmd(op, sx, sy, ex, ey), 1'b0, BLANK_VALUE);
        end

        cmd_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d draws (%0d across the full coordinate range) and %0d reads,",
                 n_draws, n_wide_draws, n_reads);
        $display("%0d reads hit lit pixels; long response hold and a full drain were exercised.",
                 n_lit_reads);
        if (error_count == 0)
        begin
            $display("tb_line_rasterizer_framebuffer_core: done, clean");
        end
        else
        begin
            $display("tb_line_rasterizer_framebuffer_core: done, errors");
        end
        $finish;
    end

endmodule
